[rtl/msp_pkg.sv]
// Shared types and codes for the music register stream player.
// No dependencies; msp_seq and the top level refer to it by scoped names.
`default_nettype none
package msp_pkg;

	// Input item commands
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Result kinds
	localparam logic [2:0] KIND_SOUND     = 3'd0;
	localparam logic [2:0] KIND_FM        = 3'd1;
	localparam logic [2:0] KIND_PUSH_OK   = 3'd2;
	localparam logic [2:0] KIND_PUSH_DROP = 3'd3;
	localparam logic [2:0] KIND_END       = 3'd4;

	// Stream command bytes
	localparam logic [7:0] BYTE_EXT = 8'h40;
	localparam logic [7:0] BYTE_END = 8'h80;

	// Result budget of one tick
	localparam logic [6:0] MAX_WRITES = 7'd64;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] reg_index;
		logic [7:0] reg_value;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

[rtl/msp_in_if.sv]
// Input channel: valid/ready handshake carrying command and stream byte.
// Depends on nothing.
`default_nettype none
interface msp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] stream_byte;

	modport source (output valid, output command, output stream_byte, input ready);
	modport sink   (input valid, input command, input stream_byte, output ready);
endinterface
`default_nettype wire

[rtl/msp_out_if.sv]
// Result channel: valid/ready handshake carrying one register write or status.
// Depends on nothing.
`default_nettype none
interface msp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] reg_index;
	logic [7:0] reg_value;
	logic       last;

	modport source (output valid, output kind, output reg_index, output reg_value,
		output last, input ready);
	modport sink   (input valid, input kind, input reg_index, input reg_value,
		input last, output ready);
endinterface
`default_nettype wire

[rtl/msp_ring.sv]
// Ring store of stream bytes: one write port, one read port with registered data.
// Contents are not reset; depends on nothing.
`default_nettype none
module msp_ring #(
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]               wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [7:0]               rd_data
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/msp_seq.sv]
// Decode sequencer: ring pointers, delay counter, command decode and result holdover.
// Drives the ring store ports; uses msp_pkg for codes and the result type.
`default_nettype none
module msp_seq #(
	parameter int unsigned RING_DEPTH   = 1024,
	parameter int unsigned HEADER_BYTES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          play_enable,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    command,
	input  wire logic [7:0]                    stream_byte,
	input  wire logic                          out_free,
	output logic                               emit_valid,
	output msp_pkg::result_t                   emit,
	output logic                               wr_en,
	output logic      [$clog2(RING_DEPTH)-1:0] wr_addr,
	output logic      [7:0]                    wr_data,
	output logic                               rd_en,
	output logic      [$clog2(RING_DEPTH)-1:0] rd_addr,
	input  wire logic [7:0]                    rd_data
);

	localparam int unsigned SPAN = 2 * RING_DEPTH;
	localparam int unsigned PW   = $clog2(SPAN);
	localparam int unsigned IW   = $clog2(RING_DEPTH);
	localparam logic [PW:0]   SPAN_X  = (PW+1)'(SPAN);
	localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(SPAN - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FETCH = 8'b0000_0010,
		S_CMD   = 8'b0000_0100,
		S_SND   = 8'b0000_1000,
		S_EXT   = 8'b0001_0000,
		S_FMREG = 8'b0010_0000,
		S_FMVAL = 8'b0100_0000,
		S_FLUSH = 8'b1000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [PW-1:0]    rp_q, rp_d, wp_q, wp_d;
	logic [6:0]       ftw_q, ftw_d;
	logic             ended_q, ended_d;
	logic [6:0]       n_q, n_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       reg_q, reg_d;
	logic [5:0]       pairs_q, pairs_d;
	logic             pend_valid_q, pend_valid_d;
	msp_pkg::result_t pend_q, pend_d;

	logic [PW:0]      diff, fill_x;
	logic [PW-1:0]    fill, avail, wp_next;
	logic             full, can_emit;

	function automatic logic [IW-1:0] ring_index(input logic [PW-1:0] p);
		logic [PW-1:0] t;
		t = (p >= DEPTH_P) ? p - DEPTH_P : p;
		return t[IW-1:0];
	endfunction

	// Fill level modulo the pointer span; above the depth the header is still arriving
	assign diff     = {1'b0, wp_q} - {1'b0, rp_q};
	assign fill_x   = diff[PW] ? diff + SPAN_X : diff;
	assign fill     = fill_x[PW-1:0];
	assign full     = (fill == DEPTH_P);
	assign avail    = (fill > DEPTH_P) ? '0 : fill;
	assign wp_next  = (wp_q == LAST_P) ? '0 : wp_q + PW'(1);
	assign can_emit = !pend_valid_q || out_free;
	assign wr_addr  = ring_index(wp_q);
	assign wr_data  = stream_byte;

	always_comb begin
		logic [6:0]       rp_inc;
		logic [1:0]       rd_off;
		logic             new_valid;
		msp_pkg::result_t new_res;
		logic [6:0]       len;
		logic [PW:0]      rp_sum, rd_sum;

		state_d      = state_q;
		rp_d         = rp_q;
		wp_d         = wp_q;
		ftw_d        = ftw_q;
		ended_d      = ended_q;
		n_d          = n_q;
		cmd_d        = cmd_q;
		reg_d        = reg_q;
		pairs_d      = pairs_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		in_ready     = 1'b0;
		emit_valid   = 1'b0;
		emit         = '0;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		rd_off       = 2'd0;
		rp_inc       = 7'd0;
		rp_sum       = '0;
		new_valid    = 1'b0;
		new_res      = '0;
		len          = 7'd2 + {1'b0, rd_data[5:0]};

		case (state_q)
			S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					case (command)
						msp_pkg::CMD_PUSH: begin
							emit_valid      = 1'b1;
							emit.kind       = full ? msp_pkg::KIND_PUSH_DROP
								: msp_pkg::KIND_PUSH_OK;
							emit.reg_value  = stream_byte;
							emit.last       = 1'b1;
							if (!full) begin
								wr_en = 1'b1;
								wp_d  = wp_next;
							end
						end
						msp_pkg::CMD_TICK: begin
							if (play_enable && !ended_q) begin
								if (ftw_q != 7'd0) begin
									ftw_d = ftw_q - 7'd1;
								end else begin
									n_d     = 7'd0;
									state_d = S_FETCH;
								end
							end
						end
						msp_pkg::CMD_RESTART: begin
							wp_d    = '0;
							rp_d    = PW'(HEADER_BYTES);
							ftw_d   = 7'd0;
							ended_d = 1'b0;
						end
						default: ;
					endcase
				end
			end
			S_FETCH: begin
				if (avail == '0) begin
					state_d = S_FLUSH;
				end else begin
					rd_en   = 1'b1;
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				cmd_d = rd_data;
				if (rd_data < msp_pkg::BYTE_EXT) begin
					if (avail < PW'(2) || n_q >= msp_pkg::MAX_WRITES) begin
						state_d = S_FLUSH;
					end else begin
						rd_en   = 1'b1;
						rd_off  = 2'd1;
						state_d = S_SND;
					end
				end else if (rd_data == msp_pkg::BYTE_EXT) begin
					if (avail < PW'(2)) begin
						state_d = S_FLUSH;
					end else begin
						rd_en   = 1'b1;
						rd_off  = 2'd1;
						state_d = S_EXT;
					end
				end else if (rd_data < msp_pkg::BYTE_END) begin
					// Whole FM block must be present and fit the budget
					if (avail < PW'({rd_data[5:0], 1'b1})
							|| (n_q + {1'b0, rd_data[5:0]}) > msp_pkg::MAX_WRITES) begin
						state_d = S_FLUSH;
					end else begin
						rd_en   = 1'b1;
						rd_off  = 2'd1;
						rp_inc  = 7'd1;
						pairs_d = rd_data[5:0];
						state_d = S_FMREG;
					end
				end else if (rd_data == msp_pkg::BYTE_END) begin
					if (n_q >= msp_pkg::MAX_WRITES) begin
						state_d = S_FLUSH;
					end else if (can_emit) begin
						new_valid    = 1'b1;
						new_res.kind = msp_pkg::KIND_END;
						ended_d      = 1'b1;
						rp_inc       = 7'd1;
						state_d      = S_FLUSH;
					end
				end else begin
					ftw_d   = rd_data[6:0] - 7'd1;
					rp_inc  = 7'd1;
					state_d = S_FLUSH;
				end
			end
			S_SND: begin
				if (can_emit) begin
					new_valid         = 1'b1;
					new_res.kind      = msp_pkg::KIND_SOUND;
					new_res.reg_index = {2'b00, cmd_q[5:0]};
					new_res.reg_value = rd_data;
					rp_inc            = 7'd2;
					state_d           = S_FETCH;
				end
			end
			S_EXT: begin
				if (avail < PW'(len)) begin
					state_d = S_FLUSH;
				end else begin
					rp_inc  = len;
					state_d = S_FETCH;
				end
			end
			S_FMREG: begin
				reg_d   = rd_data;
				rd_en   = 1'b1;
				rd_off  = 2'd1;
				state_d = S_FMVAL;
			end
			S_FMVAL: begin
				if (can_emit) begin
					new_valid         = 1'b1;
					new_res.kind      = msp_pkg::KIND_FM;
					new_res.reg_index = reg_q;
					new_res.reg_value = rd_data;
					rp_inc            = 7'd2;
					pairs_d           = pairs_q - 6'd1;
					if (pairs_q != 6'd1) begin
						rd_en   = 1'b1;
						rd_off  = 2'd2;
						state_d = S_FMREG;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					emit_valid   = 1'b1;
					emit         = pend_q;
					emit.last    = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// Hold the newest result back until the tick knows whether it is the final one
		if (new_valid) begin
			n_d = n_q + 7'd1;
			if (pend_valid_q) begin
				emit_valid = 1'b1;
				emit       = pend_q;
				emit.last  = 1'b0;
			end
			pend_d       = new_res;
			pend_valid_d = 1'b1;
		end

		// Shared pointer adder with wrap at the span
		if (rp_inc != 7'd0) begin
			rp_sum = {1'b0, rp_q} + (PW+1)'(rp_inc);
			if (rp_sum >= SPAN_X) begin
				rp_sum = rp_sum - SPAN_X;
			end
			rp_d = rp_sum[PW-1:0];
		end

		rd_sum = {1'b0, rp_q} + (PW+1)'(rd_off);
		if (rd_sum >= SPAN_X) begin
			rd_sum = rd_sum - SPAN_X;
		end
		rd_addr = ring_index(rd_sum[PW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rp_q         <= '0;
			wp_q         <= '0;
			ftw_q        <= 7'd0;
			ended_q      <= 1'b1;
			n_q          <= 7'd0;
			pairs_q      <= 6'd0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			rp_q         <= rp_d;
			wp_q         <= wp_d;
			ftw_q        <= ftw_d;
			ended_q      <= ended_d;
			n_q          <= n_d;
			pairs_q      <= pairs_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		reg_q  <= reg_d;
		pend_q <= pend_d;
	end

endmodule
`default_nettype wire

[rtl/music_register_stream_player.sv]
// Channel      Dir   Handshake      Payload
// stream_in    in    valid/ready    command[1:0], stream_byte[7:0]
// result_out   out   valid/ready    kind[2:0], reg_index[7:0], reg_value[7:0], last
// cfg          in    cfg_we         cfg_wdata = play_enable
//
// A push, restart, idle tick or delay countdown is handled without leaving S_IDLE. A
// decoding tick leaves S_IDLE and walks the ring through its single read port:
// fetch and decode each command byte, read the value of a sound write, read each
// FM register/value pair, skip an extension block, then close the tick in S_FLUSH.
// Reset leaves the ring contents undefined and marks the stream ended.
// A stalled result_out holds the sequencer; stream_in is not ready until it is idle.
// Top level: uses msp_pkg, msp_in_if, msp_out_if, msp_seq and msp_ring.
`default_nettype none
module music_register_stream_player #(
	parameter int unsigned RING_DEPTH   = 1024,
	parameter int unsigned HEADER_BYTES = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msp_in_if.sink     stream_in,
	msp_out_if.source  result_out,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);

	localparam int unsigned IW = $clog2(RING_DEPTH);

	logic             play_enable_q;
	logic             out_valid_q;
	msp_pkg::result_t out_q;
	logic             out_free;
	logic             emit_valid;
	msp_pkg::result_t emit;
	logic             wr_en, rd_en;
	logic [IW-1:0]    wr_addr, rd_addr;
	logic [7:0]       wr_data, rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_enable_q <= 1'b0;
		end else if (cfg_we) begin
			play_enable_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || result_out.ready;

	msp_seq #(
		.RING_DEPTH   (RING_DEPTH),
		.HEADER_BYTES (HEADER_BYTES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.play_enable (play_enable_q),
		.in_valid    (stream_in.valid),
		.in_ready    (stream_in.ready),
		.command     (stream_in.command),
		.stream_byte (stream_in.stream_byte),
		.out_free    (out_free),
		.emit_valid  (emit_valid),
		.emit        (emit),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	msp_ring #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: load a new item when the old one is gone or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			out_q <= emit;
		end
	end

	assign result_out.valid     = out_valid_q;
	assign result_out.kind      = out_q.kind;
	assign result_out.reg_index = out_q.reg_index;
	assign result_out.reg_value = out_q.reg_value;
	assign result_out.last      = out_q.last;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid |-> out_free)
		else $error("result loaded while output still holds an untaken item");

	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && (result_out.kind == msp_pkg::KIND_PUSH_OK
			|| result_out.kind == msp_pkg::KIND_PUSH_DROP)) |-> result_out.last)
		else $error("push result without last");

	a_push_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(stream_in.valid && stream_in.ready && stream_in.command == msp_pkg::CMD_PUSH)
		|=> (result_out.valid && result_out.reg_value == $past(stream_in.stream_byte)))
		else $error("push item did not produce its result");
`endif

endmodule
`default_nettype wire
